[design/vgpi_pkg.sv]
// Package for the voxel grid point insert block: sizes, codes, payload types, index helpers.
package vgpi_pkg;

	localparam int unsigned DIM_X = 32;
	localparam int unsigned DIM_Y = 32;
	localparam int unsigned DIM_Z = 32;
	localparam int unsigned CELLS = DIM_X * DIM_Y * DIM_Z;
	localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned LABEL_W = 16;
	localparam int unsigned OUT_IDX_W = 15;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_READ   = 3'd1,
		CMD_SET    = 3'd2,
		CMD_HOMOG  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ORIGIN_Z   = 3'd2,
		REG_INV_CELL_X = 3'd3,
		REG_INV_CELL_Y = 3'd4,
		REG_INV_CELL_Z = 3'd5,
		REG_EMPTY_CODE = 3'd6,
		REG_FREE_CODE  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [4:0]         cell_x;
		logic [4:0]         cell_y;
		logic [4:0]         cell_z;
		logic [15:0]        label;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic        occupied;
		logic [14:0] linear_index;
	} result_t;

	// Saturate a cell coordinate at the top of its axis.
	function automatic logic [31:0] sat_cell(logic [4:0] c, int unsigned dim);
		return ({27'b0, c} > 32'(dim - 1)) ? 32'(dim - 1) : {27'b0, c};
	endfunction

	// Integer part of the scaled offset: zero at or below the origin, clamped at the top.
	function automatic logic [31:0] axis_clamp(logic pos, logic [31:0] whole, int unsigned dim);
		return !pos ? 32'd0 : ((whole > 32'(dim - 1)) ? 32'(dim - 1) : whole);
	endfunction

	// x-major linear index.
	function automatic logic [31:0] linearize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		return x * 32'(DIM_Y * DIM_Z) + y * 32'(DIM_Z) + z;
	endfunction

endpackage

[design/voxel_grid_point_insert.sv]
// Voxel label store with point insert, cell read/set and whole-grid homogenize and clear.
//
//  channel   ports                          transfer
//  command   start, busy, item              start high and busy low at a rising edge
//  result    done, result                   done high for one cycle, no back-pressure
//  config    cfg_we, cfg_index, cfg_wdata   cfg_we high at a rising edge
//
// Insert passes through subtract, multiply, clamp and linearize, and write before the next
// transfer can be taken; read through access and read-out, set through access alone, and an
// unknown command is answered while the block stays idle. Homogenize and clear sweep the
// label memory one entry a cycle through its single read and write port.
// After reset the same sweep writes zero to every entry with busy high.
// done may be high in the cycle a new command is taken; results are never held.
module voxel_grid_point_insert (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  vgpi_pkg::item_t          item,
	output logic                     done,
	output vgpi_pkg::result_t        result,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [vgpi_pkg::CFG_W-1:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SWEEP = 7'b0000010,
		S_DRAIN = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_LIN   = 7'b0010000,
		S_ACC   = 7'b0100000,
		S_RD    = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] origin_q [3];
	logic [31:0] inv_q [3];
	logic [15:0] empty_q;
	logic [15:0] free_q;

	// single-cell command
	vgpi_pkg::cmd_t               op_q;
	logic [15:0]                  label_q;
	logic [vgpi_pkg::ADDR_W-1:0]  idx_q;
	logic [31:0]                  dmag_q [3];
	logic                         dpos_q [3];
	logic [31:0]                  prod_hi_q [3];

	// sweep engine
	logic [vgpi_pkg::ADDR_W-1:0]  sweep_addr_q;
	logic                         sweep_hom_q;
	logic [15:0]                  sweep_fill_q;
	logic                         sweep_resp_q;
	logic                         sweep_v_s1;
	logic [vgpi_pkg::ADDR_W-1:0]  sweep_addr_s1;
	logic                         sweep_last;

	// label memory
	logic [15:0]                  mem [vgpi_pkg::CELLS];
	logic [15:0]                  mem_rdata_q;
	logic [vgpi_pkg::ADDR_W-1:0]  mem_raddr;
	logic [vgpi_pkg::ADDR_W-1:0]  mem_waddr;
	logic [15:0]                  mem_wdata;
	logic                         mem_we;
	logic                         single_we;
	logic                         sweep_we;
	logic [15:0]                  single_wdata;

	// result
	logic                         done_q;
	vgpi_pkg::result_t            result_q;
	logic                         res_set;
	vgpi_pkg::result_t            res_d;

	logic                         accept;
	vgpi_pkg::cmd_t               cmd_in;
	logic [31:0]                  pos_in [3];
	logic [32:0]                  diff [3];
	logic [63:0]                  prod_full [3];
	logic [31:0]                  ax_idx [3];
	logic [31:0]                  cell_lin;
	logic [31:0]                  pt_lin;
	logic [14:0]                  idx_out;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cmd_in = vgpi_pkg::cmd_t'(item.command);
	assign done   = done_q;
	assign result = result_q;

	assign pos_in[0] = item.pos_x;
	assign pos_in[1] = item.pos_y;
	assign pos_in[2] = item.pos_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {pos_in[a][31], pos_in[a]} - {origin_q[a][31], origin_q[a]};
			prod_full[a] = {32'b0, dmag_q[a]} * {32'b0, inv_q[a]};
		end
		ax_idx[0] = vgpi_pkg::axis_clamp(dpos_q[0], prod_hi_q[0], vgpi_pkg::DIM_X);
		ax_idx[1] = vgpi_pkg::axis_clamp(dpos_q[1], prod_hi_q[1], vgpi_pkg::DIM_Y);
		ax_idx[2] = vgpi_pkg::axis_clamp(dpos_q[2], prod_hi_q[2], vgpi_pkg::DIM_Z);
		pt_lin = vgpi_pkg::linearize(ax_idx[0], ax_idx[1], ax_idx[2]);
		cell_lin = vgpi_pkg::linearize(vgpi_pkg::sat_cell(item.cell_x, vgpi_pkg::DIM_X),
			vgpi_pkg::sat_cell(item.cell_y, vgpi_pkg::DIM_Y),
			vgpi_pkg::sat_cell(item.cell_z, vgpi_pkg::DIM_Z));
	end

	assign sweep_last = (sweep_addr_q == vgpi_pkg::ADDR_W'(vgpi_pkg::CELLS - 1));
	assign idx_out    = 15'(32'(idx_q));

	// memory port selection; the state machine keeps single and sweep accesses apart
	always_comb begin
		single_wdata = (op_q == vgpi_pkg::CMD_SET) ? {8'b0, label_q[7:0]} : label_q;
		single_we    = (state_q == S_ACC) && (op_q != vgpi_pkg::CMD_READ);
		sweep_we     = sweep_v_s1 && (!sweep_hom_q || (mem_rdata_q != empty_q));
		mem_we       = single_we || sweep_we;
		mem_waddr    = sweep_v_s1 ? sweep_addr_s1 : idx_q;
		mem_wdata    = sweep_v_s1 ? (sweep_hom_q ? free_q : sweep_fill_q) : single_wdata;
		mem_raddr    = (state_q == S_SWEEP) ? sweep_addr_q : idx_q;
	end

	always_comb begin
		res_set = 1'b0;
		res_d   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd_in)
						vgpi_pkg::CMD_INSERT, vgpi_pkg::CMD_READ, vgpi_pkg::CMD_SET,
						vgpi_pkg::CMD_HOMOG, vgpi_pkg::CMD_CLEAR: res_set = 1'b0;
						default: res_set = 1'b1;
					endcase
				end
			end
			S_ACC: begin
				if (op_q != vgpi_pkg::CMD_READ) begin
					res_set            = 1'b1;
					res_d.cell_value   = single_wdata;
					res_d.occupied     = (single_wdata != empty_q);
					res_d.linear_index = idx_out;
				end
			end
			S_RD: begin
				res_set            = 1'b1;
				res_d.cell_value   = mem_rdata_q;
				res_d.occupied     = (mem_rdata_q != empty_q);
				res_d.linear_index = idx_out;
			end
			S_DRAIN: res_set = sweep_resp_q;
			default: res_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_addr_q <= '0;
			sweep_hom_q  <= 1'b0;
			sweep_fill_q <= '0;
			sweep_resp_q <= 1'b0;
			sweep_v_s1   <= 1'b0;
			done_q       <= 1'b0;
			origin_q[0]  <= '0;
			origin_q[1]  <= '0;
			origin_q[2]  <= '0;
			inv_q[0]     <= 32'd65536;
			inv_q[1]     <= 32'd65536;
			inv_q[2]     <= 32'd65536;
			empty_q      <= 16'd0;
			free_q       <= 16'd1;
		end else begin
			done_q     <= res_set;
			sweep_v_s1 <= (state_q == S_SWEEP);
			if (cfg_we) begin
				unique case (vgpi_pkg::cfg_reg_t'(cfg_index))
					vgpi_pkg::REG_ORIGIN_X:   origin_q[0] <= cfg_wdata;
					vgpi_pkg::REG_ORIGIN_Y:   origin_q[1] <= cfg_wdata;
					vgpi_pkg::REG_ORIGIN_Z:   origin_q[2] <= cfg_wdata;
					vgpi_pkg::REG_INV_CELL_X: inv_q[0] <= cfg_wdata;
					vgpi_pkg::REG_INV_CELL_Y: inv_q[1] <= cfg_wdata;
					vgpi_pkg::REG_INV_CELL_Z: inv_q[2] <= cfg_wdata;
					vgpi_pkg::REG_EMPTY_CODE: empty_q <= cfg_wdata[15:0];
					vgpi_pkg::REG_FREE_CODE:  free_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd_in)
							vgpi_pkg::CMD_INSERT: state_q <= S_MUL;
							vgpi_pkg::CMD_READ, vgpi_pkg::CMD_SET: state_q <= S_ACC;
							vgpi_pkg::CMD_HOMOG, vgpi_pkg::CMD_CLEAR: begin
								sweep_addr_q <= '0;
								sweep_hom_q  <= (cmd_in == vgpi_pkg::CMD_HOMOG);
								sweep_fill_q <= empty_q;
								sweep_resp_q <= 1'b1;
								state_q      <= S_SWEEP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: state_q <= S_LIN;
				S_LIN: state_q <= S_ACC;
				S_ACC: state_q <= (op_q == vgpi_pkg::CMD_READ) ? S_RD : S_IDLE;
				S_RD:  state_q <= S_IDLE;
				S_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sweep_addr_s1 <= sweep_addr_q;
		if (res_set) begin
			result_q <= res_d;
		end
		if (accept) begin
			op_q    <= cmd_in;
			label_q <= item.label;
			idx_q   <= cell_lin[vgpi_pkg::ADDR_W-1:0];
			for (int a = 0; a < 3; a++) begin
				dmag_q[a] <= diff[a][31:0];
				dpos_q[a] <= !diff[a][32] && (diff[a] != '0);
			end
		end
		if (state_q == S_MUL) begin
			for (int a = 0; a < 3; a++) begin
				prod_hi_q[a] <= prod_full[a][63:32];
			end
		end
		if (state_q == S_LIN) begin
			idx_q <= pt_lin[vgpi_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("transfer neither started work nor gave a result");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(single_we && sweep_v_s1))
		else $error("single-cell write collides with sweep write");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (32'(sweep_addr_q) <= 32'(vgpi_pkg::CELLS - 1)))
		else $error("sweep address beyond the grid");

	a_drain_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (sweep_v_s1 && (sweep_addr_s1 == 
			vgpi_pkg::ADDR_W'(vgpi_pkg::CELLS - 1))))
		else $error("drain cycle without the last sweep entry");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the voxel grid point insert block: directed table, then random phases.
module testbench;
	import vgpi_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int unsigned ITEMS_PER_PHASE = 166;
	localparam int unsigned PHASES = 5;
	localparam int unsigned SHOWN_MISMATCHES = 10;
	localparam int unsigned TOUCHED_DEPTH = 64;

	typedef struct {
		item_t   cmd_item;
		bit      fixed;
		result_t fixed_reply;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	item_t            item_bus = '0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             busy;
	logic             done;
	result_t          reply;

	// Mirror of the label store and of the grid settings
	logic [LABEL_W-1:0] grid_labels [CELLS];
	logic [31:0]        origin [3];
	logic [31:0]        inv_cell [3];
	logic [15:0]        empty_lbl;
	logic [15:0]        free_lbl;

	logic [31:0]  plan [8];
	result_t      replies_due [$];
	logic [14:0]  touched [$];
	stim_row_t    directed [$];
	int unsigned  mismatches = 0;
	int unsigned  burst_left = 0;

	voxel_grid_point_insert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item_bus),
		.done      (done),
		.result    (reply),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cell index along one axis for a Q16.16 point: floor of offset times reciprocal, clamped.
	function automatic logic [31:0] axis_cell(logic [31:0] pos, logic [31:0] org,
			logic [31:0] inv, int unsigned dim);
		logic signed [32:0] offset;
		logic [63:0]        prod;
		offset = $signed({pos[31], pos}) - $signed({org[31], org});
		if (offset <= 0)
			return 32'd0;
		prod = {31'd0, offset} * {32'd0, inv};
		if (prod[63:32] > dim - 1)
			return dim - 1;
		return prod[63:32];
	endfunction

	function automatic logic [31:0] clamp_cell(logic [4:0] c, int unsigned dim);
		return ({27'd0, c} > dim - 1) ? dim - 1 : {27'd0, c};
	endfunction

	// Apply one command to the mirror and return the reply it produces.
	function automatic result_t grid_execute(item_t it);
		logic [31:0] x, y, z;
		logic [14:0] idx;
		result_t     r;
		r = '0;
		case (it.command)
		CMD_INSERT, CMD_READ, CMD_SET: begin
			if (it.command == CMD_INSERT) begin
				x = axis_cell(it.pos_x, origin[0], inv_cell[0], DIM_X);
				y = axis_cell(it.pos_y, origin[1], inv_cell[1], DIM_Y);
				z = axis_cell(it.pos_z, origin[2], inv_cell[2], DIM_Z);
			end else begin
				x = clamp_cell(it.cell_x, DIM_X);
				y = clamp_cell(it.cell_y, DIM_Y);
				z = clamp_cell(it.cell_z, DIM_Z);
			end
			idx = 15'(x * DIM_Y * DIM_Z + y * DIM_Z + z);
			if (it.command == CMD_INSERT)
				grid_labels[idx] = it.label;
			else if (it.command == CMD_SET)
				grid_labels[idx] = {8'd0, it.label[7:0]};
			r.cell_value = grid_labels[idx];
			r.occupied = (grid_labels[idx] != empty_lbl);
			r.linear_index = idx;
		end
		CMD_HOMOG: begin
			for (int i = 0; i < CELLS; i++)
				if (grid_labels[i] != empty_lbl)
					grid_labels[i] = free_lbl;
		end
		CMD_CLEAR: begin
			for (int i = 0; i < CELLS; i++)
				grid_labels[i] = empty_lbl;
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic void add_row(logic [2:0] cmd, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [4:0] cx, logic [4:0] cy, logic [4:0] cz, logic [15:0] lbl,
			bit fixed = 1'b0, logic [15:0] val = '0, logic occ = 1'b0, logic [14:0] idx = '0);
		stim_row_t row;
		row.cmd_item = '{command: cmd, pos_x: px, pos_y: py, pos_z: pz,
			cell_x: cx, cell_y: cy, cell_z: cz, label: lbl};
		row.fixed = fixed;
		row.fixed_reply = '{cell_value: val, occupied: occ, linear_index: idx};
		directed = {directed, row};
	endfunction

	// Point position around the grid: mostly inside, some near the origin, some anywhere.
	function automatic logic [31:0] near_grid(logic [31:0] org, logic [31:0] inv);
		logic [63:0] span;
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom;
		if (r < 3)
			return org + $urandom_range(0, 32'h2_0000) - 32'h1_0000;
		span = (inv == 0) ? 64'h7FFF_FFFF : (64'd34 << 32) / inv;
		if (span > 64'h7FFF_FFFF)
			span = 64'h7FFF_FFFF;
		return org - 32'(span / 34) + $urandom_range(0, 32'(span));
	endfunction

	function automatic item_t random_item();
		item_t       it;
		int unsigned r;
		logic [14:0] idx;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		it.cell_x = 5'($urandom);
		it.cell_y = 5'($urandom);
		it.cell_z = 5'($urandom);
		it.label = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 47) begin
			it.command = CMD_INSERT;
			it.pos_x = near_grid(origin[0], inv_cell[0]);
			it.pos_y = near_grid(origin[1], inv_cell[1]);
			it.pos_z = near_grid(origin[2], inv_cell[2]);
		end else if (r < 95) begin
			it.command = (r < 77) ? CMD_READ : CMD_SET;
			// revisit cells written earlier most of the time
			if (touched.size() != 0 && $urandom_range(0, 9) < 6) begin
				idx = touched[$urandom_range(0, touched.size() - 1)];
				it.cell_x = idx[14:10];
				it.cell_y = idx[9:5];
				it.cell_z = idx[4:0];
			end
		end else begin
			it.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return it;
	endfunction

	task automatic issue(item_t it, bit fixed, result_t fixed_reply);
		result_t predicted;
		start <= 1'b1;
		item_bus <= it;
		do @(posedge clk); while (busy);
		predicted = grid_execute(it);
		replies_due = {replies_due, (fixed ? fixed_reply : predicted)};
		if (it.command == CMD_INSERT || it.command == CMD_SET) begin
			touched = {touched, predicted.linear_index};
			if (touched.size() > TOUCHED_DEPTH)
				void'(touched.pop_front());
		end
	endtask

	task automatic idle_gap();
		int unsigned r, len;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(10, 40);
		len = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 3) :
			(r < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
		if (len != 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// Hold off until every reply is in and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (replies_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic apply_plan();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= plan[i];
			@(posedge clk);
			case (cfg_reg_t'(i))
			REG_ORIGIN_X:   origin[0] = plan[i];
			REG_ORIGIN_Y:   origin[1] = plan[i];
			REG_ORIGIN_Z:   origin[2] = plan[i];
			REG_INV_CELL_X: inv_cell[0] = plan[i];
			REG_INV_CELL_Y: inv_cell[1] = plan[i];
			REG_INV_CELL_Z: inv_cell[2] = plan[i];
			REG_EMPTY_CODE: empty_lbl = plan[i][15:0];
			REG_FREE_CODE:  free_lbl = plan[i][15:0];
			default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : watch_replies
		result_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("%0t: reply with none due: value %h occ %b index %h",
						$realtime, reply.cell_value, reply.occupied, reply.linear_index);
			end else begin
				want = replies_due.pop_front();
				if (reply.cell_value !== want.cell_value || reply.occupied !== want.occupied ||
						reply.linear_index !== want.linear_index) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("%0t: reply mismatch: value %h/%h occ %b/%b index %h/%h (exp/act)",
							$realtime, want.cell_value, reply.cell_value, want.occupied,
							reply.occupied, want.linear_index, reply.linear_index);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		item_t it;
		int unsigned bulk_at;
		for (int i = 0; i < CELLS; i++)
			grid_labels[i] = '0;
		for (int a = 0; a < 3; a++) begin
			origin[a] = '0;
			inv_cell[a] = 32'h1_0000;
		end
		empty_lbl = 16'd0;
		free_lbl = 16'd1;

		// fresh store, extremes of position, set keeping the low byte, spare codes, bulk commands
		add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_READ, 0, 0, 0, 31, 31, 31, 16'hFFFF, 1, 16'h0000, 0, 15'h7FFF);
		add_row(CMD_INSERT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1, 16'hFFFF, 1, 15'h0000);
		add_row(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31, 31, 31, 16'h1234,
			1, 16'h1234, 1, 15'h7FFF);
		add_row(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16'h0001,
			1, 16'h0001, 1, 15'h0000);
		add_row(CMD_INSERT, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 16'h00AA);
		add_row(CMD_INSERT, 32'h0_FFFF, 32'h2_0000, 32'h1_FFFF, 0, 0, 0, 16'h5555);
		add_row(CMD_SET, 0, 0, 0, 5, 6, 7, 16'hABCD);
		add_row(CMD_SET, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 16'hFF00, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_READ, 0, 0, 0, 5, 6, 7, 16'h0000);
		add_row(CMD_SPARE_LO, 32'h7FFF_FFFF, 0, 0, 31, 0, 0, 16'hFFFF, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_SPARE_LO + 3'd1, 0, 0, 0, 1, 2, 3, 16'h00FF, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_SPARE_HI, 0, 0, 32'h8000_0000, 0, 0, 31, 16'h0F0F, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_READ, 0, 0, 0, 2, 0, 1, 16'h0000);
		add_row(CMD_HOMOG, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_READ, 0, 0, 0, 31, 31, 31, 16'h0000);
		add_row(CMD_READ, 0, 0, 0, 5, 6, 7, 16'h0000);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 16'h0000, 1, 16'h0000, 0, 15'h0000);
		add_row(CMD_READ, 0, 0, 0, 31, 31, 31, 16'h0000, 1, 16'h0000, 0, 15'h7FFF);
		add_row(CMD_INSERT, 32'h1F_0000, 32'h1F_0000, 32'h1F_0000, 0, 0, 0, 16'h0000);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// wait out the clearing pass after reset
		while (busy)
			@(posedge clk);

		foreach (directed[i]) begin
			issue(directed[i].cmd_item, directed[i].fixed, directed[i].fixed_reply);
			idle_gap();
		end
		drain();

		for (int phase = 1; phase <= PHASES; phase++) begin
			for (int a = 0; a < 3; a++) begin
				case (phase)
				2: begin
					plan[REG_ORIGIN_X + a] = 32'h8000_0000;
					plan[REG_INV_CELL_X + a] = 32'hFFFF_FFFF;
				end
				3: begin
					plan[REG_ORIGIN_X + a] = 32'h7FFF_FFFF;
					plan[REG_INV_CELL_X + a] = 32'h0;
				end
				4: begin
					plan[REG_ORIGIN_X + a] = $urandom;
					plan[REG_INV_CELL_X + a] = $urandom;
				end
				default: begin
					plan[REG_ORIGIN_X + a] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
					plan[REG_INV_CELL_X + a] = $urandom_range(32'h4000, 32'h4_0000);
				end
				endcase
			end
			case (phase)
			2: begin
				plan[REG_EMPTY_CODE] = 32'hFFFF;
				plan[REG_FREE_CODE] = 32'h0;
			end
			3: begin
				plan[REG_EMPTY_CODE] = 32'h0;
				plan[REG_FREE_CODE] = 32'hFFFF;
			end
			PHASES: begin
				plan[REG_EMPTY_CODE] = 32'h0;
				plan[REG_FREE_CODE] = $urandom_range(0, 16'hFFFF);
			end
			default: begin
				plan[REG_EMPTY_CODE] = $urandom_range(0, 16'hFFFF);
				plan[REG_FREE_CODE] = $urandom_range(0, 16'hFFFF);
			end
			endcase
			apply_plan();

			bulk_at = $urandom_range(ITEMS_PER_PHASE / 4, ITEMS_PER_PHASE - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it = random_item();
				// one whole-grid sweep per phase, alternating between the two kinds
				if (n == bulk_at)
					it.command = (phase % 2) ? CMD_HOMOG : CMD_CLEAR;
				issue(it, 1'b0, '0);
				if ($urandom_range(0, 49) == 0)
					drain();
				else
					idle_gap();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
design/vgpi_pkg.sv
design/voxel_grid_point_insert.sv
tb/testbench.sv
